// ===== rtl/utbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unsigned to base symbols: shared package
// Register indexes, field widths and sign bytes used by the unit and its
// checker.
// ----------------------------------------------------------------------------
package utbs_pkg;

    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned SYM_W       = 8;
    localparam int unsigned SLOTS       = 16;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned DIGIT_MAX   = 64;
    localparam int unsigned DIGIT_PTR_W = 6;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_BASE_LENGTH  = 2'd0;
    localparam t_cfg_idx REG_SYMBOLS_LOW  = 2'd1;
    localparam t_cfg_idx REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;

endpackage

// ===== rtl/unsigned_to_base_symbols_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unsigned to base symbols unit
// Writes a 64-bit unsigned value as a stream of symbol bytes in a configured
// radix, most significant digit first.
// ----------------------------------------------------------------------------
// Usage. The symbol table and its length are written through i_cfg_we,
// i_cfg_idx and i_cfg_wdata; the user must write them only while busy is
// low, which the unit itself does not enforce. A write takes effect at once.
// A value is transferred at a clock edge with start high and busy low. A
// length out of range refuses the value; else the table is checked, one
// slot a cycle, and a bad symbol ends the job with no results. Each digit is
// then found in a single bit-serial restoring divider, one quotient bit a
// cycle, with the digits held in a 64-entry memory. The digits are then read
// back, one a cycle, and each is shown for one cycle with o_valid, o_last on
// the final one. The last digit is shown in the first cycle in which busy is
// low. Busy stays high until the last digit has been read.
// The receiver cannot stall: every result is transferred in the cycle in
// which o_valid is high. A synchronous reset returns the unit to idle and
// clears the configuration registers.
// ----------------------------------------------------------------------------
module unsigned_to_base_symbols_unit
    import utbs_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  t_cfg_idx               i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   start,
    input  logic [VALUE_W-1:0]     i_value,
    output logic                   busy,
    output logic                   o_valid,
    output logic [SYM_W-1:0]       o_symbol,
    output logic                   o_last,
    output logic [COUNT_W-1:0]     o_digit_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                 r_state, n_state;
    logic [LEN_W-1:0]       r_len;
    logic [CFG_DATA_W-1:0]  r_sym_lo, r_sym_hi;
    logic [SLOT_W-1:0]      r_idx, n_idx;
    logic [VALUE_W-1:0]     r_quot, n_quot;
    logic [SLOT_W-1:0]      r_rem, n_rem;
    logic [DIGIT_PTR_W-1:0] r_bit, n_bit;
    logic [COUNT_W-1:0]     r_count, n_count;
    logic [DIGIT_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic                   r_rd_valid, n_rd_valid;
    logic                   r_rd_last, n_rd_last;
    logic [SLOT_W-1:0]      r_rd_digit;
    logic [SLOT_W-1:0]      r_digits [DIGIT_MAX];

    logic [SYM_W-1:0]       w_sym [SLOTS];
    logic                   w_len_ok;
    logic                   w_dup;
    logic                   w_bad;
    logic [LEN_W-1:0]       w_shift;
    logic                   w_ge;
    logic [LEN_W-1:0]       w_diff;
    logic [SLOT_W-1:0]      w_step_rem;
    logic [VALUE_W-1:0]     w_step_quot;
    logic                   w_wr_en;
    logic                   w_rd_en;

    always_comb begin
        for (int s = 0; s < SLOTS / 2; s++) begin
            w_sym[s]             = r_sym_lo[s*SYM_W +: SYM_W];
            w_sym[s + SLOTS / 2] = r_sym_hi[s*SYM_W +: SYM_W];
        end
    end

    assign w_len_ok = (r_len >= LEN_W'(2)) && (r_len <= LEN_W'(MAX_SYMBOLS));

    always_comb begin
        w_dup = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if ((SLOT_W'(j) < r_idx) && (w_sym[j] == w_sym[r_idx])) begin
                w_dup = 1'b1;
            end
        end
    end

    assign w_bad = w_dup || (w_sym[r_idx] == SIGN_PLUS) || (w_sym[r_idx] == SIGN_MINUS);

    assign w_shift     = {r_rem, r_quot[VALUE_W-1]};
    assign w_ge        = (w_shift >= r_len);
    assign w_diff      = w_shift - r_len;
    assign w_step_rem  = w_ge ? w_diff[SLOT_W-1:0] : w_shift[SLOT_W-1:0];
    assign w_step_quot = {r_quot[VALUE_W-2:0], w_ge};

    assign w_wr_en = (r_state == ST_DIV) && (r_bit == DIGIT_PTR_W'(DIGIT_MAX - 1));
    assign w_rd_en = (r_state == ST_OUT);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_quot     = r_quot;
        n_rem      = r_rem;
        n_bit      = r_bit;
        n_count    = r_count;
        n_rd_ptr   = r_rd_ptr;
        n_rd_valid = 1'b0;
        n_rd_last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_quot  = i_value;
                    n_idx   = '0;
                    n_rem   = '0;
                    n_bit   = '0;
                    n_count = '0;
                    if (w_len_ok) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (w_bad) begin
                    n_state = ST_IDLE;
                end else if ({1'b0, r_idx} == r_len - LEN_W'(1)) begin
                    n_state = ST_DIV;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            ST_DIV: begin
                n_quot = w_step_quot;
                n_rem  = w_step_rem;
                n_bit  = r_bit + DIGIT_PTR_W'(1);
                if (w_wr_en) begin
                    n_count = r_count + COUNT_W'(1);
                    n_rem   = '0;
                    if ((w_step_quot == '0) || (r_count >= COUNT_W'(DIGIT_MAX - 1))) begin
                        n_rd_ptr = r_count[DIGIT_PTR_W-1:0];
                        n_state  = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                n_rd_valid = 1'b1;
                n_rd_last  = (r_rd_ptr == '0);
                if (r_rd_ptr == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_rd_ptr = r_rd_ptr - DIGIT_PTR_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_len      <= '0;
            r_sym_lo   <= '0;
            r_sym_hi   <= '0;
            r_rd_valid <= 1'b0;
            r_rd_last  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= n_rd_valid;
            r_rd_last  <= n_rd_last;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BASE_LENGTH:  r_len    <= i_cfg_wdata[LEN_W-1:0];
                    REG_SYMBOLS_LOW:  r_sym_lo <= i_cfg_wdata;
                    REG_SYMBOLS_HIGH: r_sym_hi <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        r_idx    <= n_idx;
        r_quot   <= n_quot;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
        r_count  <= n_count;
        r_rd_ptr <= n_rd_ptr;
    end

    // Digit memory: least significant digit at address zero.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_digits[r_count[DIGIT_PTR_W-1:0]] <= w_step_rem;
        end
        if (w_rd_en) begin
            r_rd_digit <= r_digits[r_rd_ptr];
        end
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_rd_valid;
    assign o_last        = r_rd_last;
    assign o_symbol      = w_sym[r_rd_digit];
    assign o_digit_count = r_count;

endmodule

// ===== rtl/utbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unsigned to base symbols: port checker
// Watches the result stream of the unit for gaps, count changes, counts out
// of range, a transfer right after the last digit and results outside a job.
// ----------------------------------------------------------------------------
module utbs_port_checker
    import utbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               busy,
    input  logic               o_valid,
    input  logic               o_last,
    input  logic [COUNT_W-1:0] o_digit_count
);

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("Digit stream broke off before its last transfer.");

    a_count_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_digit_count == $past(o_digit_count))
        else $error("Digit count changed within one value.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_count != '0) && (o_digit_count <= COUNT_W'(DIGIT_MAX)))
        else $error("Digit count out of range.");

    a_end_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("Transfer directly after the last digit.");

    a_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy))
        else $error("Result stream began outside a job.");

endmodule

bind unsigned_to_base_symbols_unit utbs_port_checker u_utbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_last        (o_last),
    .o_digit_count (o_digit_count)
);

// ===== verif/utbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unsigned to base symbols: checker
// Follows the configuration writes and every accepted value, works out the
// digit symbols that the unit must produce, and compares each result
// strobe with the oldest outstanding digit. Failures and the number of
// outstanding digits are handed to the testbench top.
// ----------------------------------------------------------------------------
module utbs_checker
    import utbs_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_start,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic                  i_busy,
    input  logic                  i_valid,
    input  logic [SYM_W-1:0]      i_symbol,
    input  logic                  i_last,
    input  logic [COUNT_W-1:0]    i_digit_count,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_symbols_checked
);

    typedef struct packed {
        logic [SYM_W-1:0]   symbol;
        logic               last;
        logic [COUNT_W-1:0] digit_count;
    } t_digit;

    logic [LEN_W-1:0]      base_len;
    logic [CFG_DATA_W-1:0] sym_lo;
    logic [CFG_DATA_W-1:0] sym_hi;
    t_digit                expected_digits[$];
    t_digit                oldest;

    initial begin
        o_fail_count      = 0;
        o_pending         = 0;
        o_symbols_checked = 0;
    end

    function automatic logic [SYM_W-1:0] slot_symbol(input int unsigned slot);
        logic [CFG_DATA_W-1:0] word;
        word = (slot < 8) ? sym_lo : sym_hi;
        return word[(slot % 8) * SYM_W +: SYM_W];
    endfunction

    function automatic bit table_ok();
        int unsigned i;
        int unsigned j;
        if (base_len < 2 || base_len > MAX_SYMBOLS)
            return 1'b0;
        for (i = 0; i < base_len; i++) begin
            if (slot_symbol(i) == SIGN_PLUS || slot_symbol(i) == SIGN_MINUS)
                return 1'b0;
            for (j = 0; j < i; j++) begin
                if (slot_symbol(j) == slot_symbol(i))
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Repeated division gives the digits least significant first; they are
    // queued most significant first, as the unit sends them.
    function automatic void predict_digits(input logic [VALUE_W-1:0] value);
        logic [SLOT_W-1:0]  digits_ls [DIGIT_MAX];
        logic [VALUE_W-1:0] rest;
        logic [VALUE_W-1:0] radix;
        int                 n;
        int                 k;
        t_digit             d;
        if (!table_ok())
            return;
        rest  = value;
        radix = VALUE_W'(base_len);
        n     = 0;
        do begin
            digits_ls[n] = SLOT_W'(rest % radix);
            rest         = rest / radix;
            n++;
        end while (rest != 0 && n < DIGIT_MAX);
        for (k = n - 1; k >= 0; k--) begin
            d.symbol      = slot_symbol(digits_ls[k]);
            d.last        = (k == 0);
            d.digit_count = COUNT_W'(n);
            expected_digits.push_back(d);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_len = '0;
            sym_lo   = '0;
            sym_hi   = '0;
            expected_digits.delete();
        end else begin
            if (i_valid) begin
                if (expected_digits.size() == 0) begin
                    o_fail_count++;
                    $display("%0t ns: unexpected symbol, expected none, actual %h last %0b count %0d",
                             $time, i_symbol, i_last, i_digit_count);
                end else begin
                    oldest = expected_digits.pop_front();
                    o_symbols_checked++;
                    if (i_symbol !== oldest.symbol) begin
                        o_fail_count++;
                        $display("%0t ns: symbol mismatch, expected %h, actual %h",
                                 $time, oldest.symbol, i_symbol);
                    end
                    if (i_last !== oldest.last) begin
                        o_fail_count++;
                        $display("%0t ns: last mismatch, expected %0b, actual %0b",
                                 $time, oldest.last, i_last);
                    end
                    if (i_digit_count !== oldest.digit_count) begin
                        o_fail_count++;
                        $display("%0t ns: digit count mismatch, expected %0d, actual %0d",
                                 $time, oldest.digit_count, i_digit_count);
                    end
                end
            end
            if (i_start && !i_busy)
                predict_digits(i_value);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BASE_LENGTH:  base_len = i_cfg_wdata[LEN_W-1:0];
                    REG_SYMBOLS_LOW:  sym_lo = i_cfg_wdata;
                    REG_SYMBOLS_HIGH: sym_hi = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        o_pending = expected_digits.size();
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unsigned to base symbols: testbench top
// Programs a series of symbol tables, valid and invalid, and sends directed
// and random values through the unit with random idle cycles. The checker
// beside the unit predicts and compares every digit; this module makes the
// stimulus, runs a watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import utbs_pkg::*;

    localparam int unsigned MAX_SYMBOLS        = 16;
    localparam int unsigned IDLE_LIMIT         = 20000;
    localparam int unsigned SETTLE_CYCLES      = 20;
    localparam int unsigned DRAIN_CYCLES       = 100;
    localparam int unsigned GAP_PCT            = 18;
    localparam int unsigned RANDOM_VALID_ITEMS = 105;
    localparam t_cfg_idx    REG_UNUSED         = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_SIGN,
        FLAW_DUP,
        FLAW_LENGTH
    } t_flaw;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    t_cfg_idx              i_cfg_idx   = REG_BASE_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  start       = 1'b0;
    logic [VALUE_W-1:0]    i_value     = '0;
    logic                  busy;
    logic                  o_valid;
    logic [SYM_W-1:0]      o_symbol;
    logic                  o_last;
    logic [COUNT_W-1:0]    o_digit_count;

    int fail_count;
    int pending;
    int symbols_checked;
    int idle_cycles = 0;
    int values_sent = 0;
    int values_dropped = 0;
    int tables_used = 0;
    bit gaps_on = 1'b1;
    bit table_good = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    unsigned_to_base_symbols_unit #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .start(start),
        .i_value(i_value),
        .busy(busy),
        .o_valid(o_valid),
        .o_symbol(o_symbol),
        .o_last(o_last),
        .o_digit_count(o_digit_count)
    );

    utbs_checker #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_start(start),
        .i_value(i_value),
        .i_busy(busy),
        .i_valid(o_valid),
        .i_symbol(o_symbol),
        .i_last(o_last),
        .i_digit_count(o_digit_count),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_symbols_checked(symbols_checked)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Holds the value until a transfer happens; start drops at random cycles
    // while gaps are enabled, so idle cycles land on every phase of a job.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        bit done;
        done = 1'b0;
        i_value <= value;
        while (!done) begin
            start <= !(gaps_on && $urandom_range(99) < GAP_PCT);
            @(negedge i_clk);
            done = start && !busy;
            @(posedge i_clk);
        end
        if (table_good)
            values_sent++;
        else
            values_dropped++;
    endtask

    task automatic wait_quiet();
        bit done;
        done = 1'b0;
        start <= 1'b0;
        while (!done) begin
            @(negedge i_clk);
            done = !busy && pending == 0;
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_table(input int unsigned len, input logic [CFG_DATA_W-1:0] lo,
                                 input logic [CFG_DATA_W-1:0] hi, input bit good);
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_BASE_LENGTH, CFG_DATA_W'(len));
        write_reg(REG_SYMBOLS_LOW, lo);
        write_reg(REG_SYMBOLS_HIGH, hi);
        table_good = good;
        tables_used++;
    endtask

    // Sixteen distinct bytes, no sign byte, then the flaw or a sign past len.
    function automatic void make_table(input int unsigned len, input t_flaw flaw,
                                       output logic [CFG_DATA_W-1:0] lo,
                                       output logic [CFG_DATA_W-1:0] hi);
        logic [SYM_W-1:0] slot_bytes [SLOTS];
        bit               used [256];
        logic [SYM_W-1:0] b;
        int unsigned      i;
        for (i = 0; i < SLOTS; i++) begin
            do b = SYM_W'($urandom_range(255));
            while (used[b] || b == SIGN_PLUS || b == SIGN_MINUS);
            used[b]       = 1'b1;
            slot_bytes[i] = b;
        end
        if (flaw == FLAW_SIGN)
            slot_bytes[$urandom_range(len - 1)] = $urandom_range(1) ? SIGN_PLUS : SIGN_MINUS;
        if (flaw == FLAW_DUP) begin
            i             = $urandom_range(len - 1, 1);
            slot_bytes[i] = slot_bytes[$urandom_range(i - 1)];
        end
        if (flaw == FLAW_NONE && len < SLOTS && $urandom_range(1))
            slot_bytes[len] = $urandom_range(1) ? SIGN_PLUS : SIGN_MINUS;
        for (i = 0; i < 8; i++) begin
            lo[i * SYM_W +: SYM_W] = slot_bytes[i];
            hi[i * SYM_W +: SYM_W] = slot_bytes[i + 8];
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input int unsigned len);
        logic [VALUE_W-1:0] radix;
        logic [VALUE_W-1:0] p;
        logic [VALUE_W-1:0] v;
        int unsigned        k;
        radix = (len < 2 || len > MAX_SYMBOLS) ? 64'd10 : VALUE_W'(len);
        case ($urandom_range(3))
            0: v = {$urandom, $urandom};
            1: v = VALUE_W'($urandom_range(32'(radix * radix)));
            2: v = {$urandom, $urandom} >> $urandom_range(63);
            default: begin
                p = 64'd1;
                k = $urandom_range(64, 1);
                while (k > 0 && p <= ({VALUE_W{1'b1}} / radix)) begin
                    p = p * radix;
                    k--;
                end
                v = $urandom_range(1) ? p : p - 64'd1;
            end
        endcase
        return v;
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        int unsigned           len;
        int unsigned           n;
        int unsigned           k;
        int unsigned           phase;
        int                    random_good;
        t_flaw                 flaw;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Decimal digits, including zero and the largest value.
        program_table(10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938, 1'b1);
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value({VALUE_W{1'b1}});
        send_value(64'd12345678901234567890);

        // Binary with a zero byte and an all-ones byte as symbols.
        program_table(2, 64'h0000_0000_0000_FF00, 64'h0, 1'b1);
        send_value({VALUE_W{1'b1}});
        send_value(64'd0);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h5555_5555_5555_5555);

        // Full sixteen-symbol table.
        program_table(16, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, 1'b1);
        send_value({VALUE_W{1'b1}});
        send_value(64'h0123_4567_89AB_CDEF);
        send_value(64'd16);

        // A write to the spare index must leave the table untouched.
        wait_quiet();
        write_reg(REG_UNUSED, {CFG_DATA_W{1'b1}});
        send_value(64'hDEAD_BEEF);

        // Only the low bits of a length write count: this selects radix three.
        wait_quiet();
        write_reg(REG_BASE_LENGTH, 64'hFFFF_FFFF_FFFF_FFE3);
        send_value({VALUE_W{1'b1}});

        // Sign bytes beyond the length in use are ignored.
        program_table(3, 64'h0000_002D_2B32_3130, 64'h0, 1'b1);
        send_value(64'd100);

        // Invalid tables: lengths out of range, sign bytes and duplicates.
        program_table(0, 64'h3736_3534_3332_3130, 64'h0, 1'b0);
        send_value(64'd5);
        program_table(1, 64'h3736_3534_3332_3130, 64'h0, 1'b0);
        send_value(64'd5);
        program_table(17, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, 1'b0);
        send_value(64'd5);
        program_table(31, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, 1'b0);
        send_value(64'd5);
        program_table(4, 64'h0000_0000_3B2B_3130, 64'h0, 1'b0);
        send_value(64'd5);
        program_table(4, 64'h0000_0000_2D32_3130, 64'h0, 1'b0);
        send_value(64'd5);
        program_table(3, 64'h0, 64'h0, 1'b0);
        send_value(64'd5);

        random_good = 0;
        phase       = 0;
        while (random_good < RANDOM_VALID_ITEMS) begin
            flaw = (phase > 1 && $urandom_range(5) == 0) ? t_flaw'($urandom_range(3, 1))
                                                         : FLAW_NONE;
            if (flaw == FLAW_LENGTH)
                len = $urandom_range(1) ? $urandom_range(1) : $urandom_range(31, 17);
            else
                len = $urandom_range(MAX_SYMBOLS, 2);
            make_table(len, flaw, lo, hi);
            program_table(len, lo, hi, flaw == FLAW_NONE);
            gaps_on = (phase != 2);
            n = (flaw == FLAW_NONE) ? $urandom_range(16, 8) : $urandom_range(4, 2);
            for (k = 0; k < n; k++) begin
                if (k == n / 2 && phase % 3 == 0)
                    wait_quiet();
                send_value(pick_value(len));
                if (flaw == FLAW_NONE)
                    random_good++;
            end
            phase++;
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("summary: %0d values converted and %0d refused over %0d table settings",
                 values_sent, values_dropped, tables_used);
        $display("summary: %0d digit symbols compared, radix 2 to 16 and invalid tables",
                 symbols_checked);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
